FILE: src/lbts_pkg.sv
// ============================================================================
// lbts_pkg
// Shared types and fixed constants for the LRU block tag store.
// ============================================================================
package lbts_pkg;

    // Fixed widths of the external fields
    localparam int unsigned PORT_ID_W = 32;
    localparam int unsigned SLOT_W    = 4;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DECIDE,
        ST_UPD,
        ST_DONE
    } seq_state_t;

    // Strobes from the sequencer to the entry store
    typedef struct packed {
        logic rd_en;
        logic tag_we;
        logic rank_we;
        logic set_valid;
    } store_ctl_t;

endpackage

FILE: src/lbts_store.sv
// ============================================================================
// lbts_store
// Entry storage: tag memory, recency-rank memory and per-entry valid bits.
// ============================================================================
module lbts_store #(
    parameter int unsigned CAPACITY      = 16,
    parameter int unsigned BLOCK_ID_BITS = 32,
    localparam int unsigned AW           = $clog2(CAPACITY)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lbts_pkg::store_ctl_t     ctl,
    input  logic [AW-1:0]            rd_addr,
    input  logic [AW-1:0]            wr_addr,
    input  logic [BLOCK_ID_BITS-1:0] wr_tag,
    input  logic [AW-1:0]            wr_rank,
    output logic [BLOCK_ID_BITS-1:0] rd_tag,
    output logic [AW-1:0]            rd_rank,
    output logic [CAPACITY-1:0]      valid_vec
);

    logic [BLOCK_ID_BITS-1:0] tag_mem  [CAPACITY];
    logic [AW-1:0]            rank_mem [CAPACITY];
    logic [BLOCK_ID_BITS-1:0] rd_tag_reg;
    logic [AW-1:0]            rd_rank_reg;
    logic [CAPACITY-1:0]      valid_reg;

    // Write ports and registered read port
    always_ff @(posedge aclk) begin
        if (ctl.tag_we) begin
            tag_mem[wr_addr] <= wr_tag;
        end
        if (ctl.rank_we) begin
            rank_mem[wr_addr] <= wr_rank;
        end
        if (ctl.rd_en) begin
            rd_tag_reg  <= tag_mem[rd_addr];
            rd_rank_reg <= rank_mem[rd_addr];
        end
    end

    // Valid bits: cleared at reset, set when an entry is filled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.set_valid) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_tag    = rd_tag_reg;
    assign rd_rank   = rd_rank_reg;
    assign valid_vec = valid_reg;

endmodule

FILE: src/lbts_ctrl.sv
// ============================================================================
// lbts_ctrl
// Sequencer with one shared tag/rank compare unit. A lookup pass scans every
// entry, a decide step picks the slot, and an update pass re-ranks entries.
// ============================================================================
module lbts_ctrl #(
    parameter int unsigned CAPACITY      = 16,
    parameter int unsigned BLOCK_ID_BITS = 32,
    localparam int unsigned AW           = $clog2(CAPACITY),
    localparam int unsigned CW           = AW + 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // request side
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [BLOCK_ID_BITS-1:0] in_id,
    // entry store side
    output lbts_pkg::store_ctl_t     ctl,
    output logic [AW-1:0]            rd_addr,
    output logic [AW-1:0]            wr_addr,
    output logic [BLOCK_ID_BITS-1:0] wr_tag,
    output logic [AW-1:0]            wr_rank,
    input  logic [BLOCK_ID_BITS-1:0] rd_tag,
    input  logic [AW-1:0]            rd_rank,
    input  logic [CAPACITY-1:0]      valid_vec,
    // result side
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic                     res_hit,
    output logic [AW-1:0]            res_slot,
    output logic                     res_evict,
    output logic [BLOCK_ID_BITS-1:0] res_victim
);

    lbts_pkg::seq_state_t state_reg, state_next;

    logic [CW-1:0]            idx_reg, idx_next;
    logic                     chk_vld_reg, chk_vld_next;
    logic [AW-1:0]            chk_idx_reg, chk_idx_next;
    logic [BLOCK_ID_BITS-1:0] id_reg, id_next;
    logic                     found_reg, found_next;
    logic [AW-1:0]            hit_slot_reg, hit_slot_next;
    logic [AW-1:0]            hit_rank_reg, hit_rank_next;
    logic                     lru_found_reg, lru_found_next;
    logic [AW-1:0]            lru_slot_reg, lru_slot_next;
    logic [BLOCK_ID_BITS-1:0] lru_tag_reg, lru_tag_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            slot_reg, slot_next;
    logic [CW-1:0]            limit_reg, limit_next;
    logic                     hit_reg, hit_next;
    logic                     evict_reg, evict_next;
    logic [BLOCK_ID_BITS-1:0] victim_reg, victim_next;

    logic                     chk_entry_vld;

    assign chk_entry_vld = valid_vec[chk_idx_reg];

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lbts_pkg::ST_IDLE;
            idx_reg     <= '0;
            chk_vld_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            chk_vld_reg <= chk_vld_next;
            count_reg   <= count_next;
        end
    end

    // Working and result payload
    always_ff @(posedge aclk) begin
        chk_idx_reg   <= chk_idx_next;
        id_reg        <= id_next;
        found_reg     <= found_next;
        hit_slot_reg  <= hit_slot_next;
        hit_rank_reg  <= hit_rank_next;
        lru_found_reg <= lru_found_next;
        lru_slot_reg  <= lru_slot_next;
        lru_tag_reg   <= lru_tag_next;
        slot_reg      <= slot_next;
        limit_reg     <= limit_next;
        hit_reg       <= hit_next;
        evict_reg     <= evict_next;
        victim_reg    <= victim_next;
    end

    // Next state and store strobes
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        id_next        = id_reg;
        found_next     = found_reg;
        hit_slot_next  = hit_slot_reg;
        hit_rank_next  = hit_rank_reg;
        lru_found_next = lru_found_reg;
        lru_slot_next  = lru_slot_reg;
        lru_tag_next   = lru_tag_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        limit_next     = limit_reg;
        hit_next       = hit_reg;
        evict_next     = evict_reg;
        victim_next    = victim_reg;
        ctl            = '0;
        rd_addr        = idx_reg[AW-1:0];
        wr_addr        = chk_idx_reg;
        wr_rank        = '0;
        in_ready       = 1'b0;
        res_valid      = 1'b0;

        unique case (state_reg)
            lbts_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    id_next        = in_id;
                    idx_next       = '0;
                    found_next     = 1'b0;
                    lru_found_next = 1'b0;
                    state_next     = lbts_pkg::ST_LOOK;
                end
            end

            lbts_pkg::ST_LOOK: begin
                // issue one entry read per cycle
                if (idx_reg < CW'(CAPACITY)) begin
                    ctl.rd_en    = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = idx_reg[AW-1:0];
                end
                // compare the entry read last cycle
                if (chk_vld_reg) begin
                    if (chk_entry_vld && rd_tag == id_reg && !found_reg) begin
                        found_next    = 1'b1;
                        hit_slot_next = chk_idx_reg;
                        hit_rank_next = rd_rank;
                    end
                    if (chk_entry_vld && rd_rank == AW'(CAPACITY - 1) && !lru_found_reg) begin
                        lru_found_next = 1'b1;
                        lru_slot_next  = chk_idx_reg;
                        lru_tag_next   = rd_tag;
                    end else if (chk_idx_reg == '0 && !lru_found_reg) begin
                        // fall back on slot zero if no oldest entry turns up
                        lru_slot_next = '0;
                        lru_tag_next  = rd_tag;
                    end
                    if (chk_idx_reg == AW'(CAPACITY - 1)) begin
                        state_next = lbts_pkg::ST_DECIDE;
                    end
                end
            end

            lbts_pkg::ST_DECIDE: begin
                idx_next = '0;
                if (found_reg) begin
                    slot_next   = hit_slot_reg;
                    limit_next  = CW'(hit_rank_reg);
                    hit_next    = 1'b1;
                    evict_next  = 1'b0;
                    victim_next = '0;
                end else if (count_reg != CW'(CAPACITY)) begin
                    // fill the next free slot
                    slot_next     = count_reg[AW-1:0];
                    limit_next    = CW'(CAPACITY);
                    hit_next      = 1'b0;
                    evict_next    = 1'b0;
                    victim_next   = '0;
                    count_next    = count_reg + 1'b1;
                    ctl.tag_we    = 1'b1;
                    ctl.set_valid = 1'b1;
                end else begin
                    // replace the least recently used entry
                    slot_next     = lru_slot_reg;
                    limit_next    = CW'(CAPACITY - 1);
                    hit_next      = 1'b0;
                    evict_next    = valid_vec[lru_slot_reg];
                    victim_next   = valid_vec[lru_slot_reg] ? lru_tag_reg : '0;
                    ctl.tag_we    = 1'b1;
                    ctl.set_valid = 1'b1;
                end
                wr_addr    = slot_next;
                state_next = lbts_pkg::ST_UPD;
            end

            lbts_pkg::ST_UPD: begin
                if (idx_reg < CW'(CAPACITY)) begin
                    ctl.rd_en    = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = idx_reg[AW-1:0];
                end
                // age or promote the entry read last cycle
                if (chk_vld_reg) begin
                    if (chk_idx_reg == slot_reg) begin
                        ctl.rank_we = 1'b1;
                        wr_rank     = '0;
                    end else if (chk_entry_vld) begin
                        ctl.rank_we = 1'b1;
                        wr_rank     = (CW'(rd_rank) < limit_reg) ? rd_rank + 1'b1 : rd_rank;
                    end
                    if (chk_idx_reg == AW'(CAPACITY - 1)) begin
                        state_next = lbts_pkg::ST_DONE;
                    end
                end
            end

            lbts_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = lbts_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = lbts_pkg::ST_IDLE;
            end
        endcase
    end

    assign wr_tag     = id_reg;
    assign res_hit    = hit_reg;
    assign res_slot   = slot_reg;
    assign res_evict  = evict_reg;
    assign res_victim = victim_reg;

    // Fill count tracks the valid bits
    a_count_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == count_reg)
        else $error("fill count differs from number of valid entries");

    // Fill count never passes capacity
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // A hit never evicts, an eviction only happens on a full store
    a_evict_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lbts_pkg::ST_DONE |-> !(hit_reg && evict_reg)
            && (!evict_reg || count_reg == CW'(CAPACITY)))
        else $error("eviction on hit or on a store that is not full");

    // The reported slot holds a valid entry
    a_slot_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lbts_pkg::ST_DONE |-> valid_vec[slot_reg])
        else $error("result slot is not valid");

endmodule

FILE: src/lru_block_tag_store_unit.sv
// ============================================================================
// lru_block_tag_store_unit
// Fully associative block tag store with strict LRU replacement.
// ============================================================================
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  s_       | in        | s_valid / s_ready  | s_block_id
//  m_       | out       | m_valid / m_ready  | m_hit, m_slot, m_evicted,
//           |           |                    | m_victim_block_id
//
//  From acceptance of a transaction until its result is loaded, a lookup
//  pass and a rank update pass each walk all entries through the single
//  registered read port of the entry store.
//  Synchronous active-low reset clears valid bits and fill count; no clearing
//  pass is needed. A result waits in the output register while the next
//  transaction is accepted; the sequencer holds at its end until that
//  register is free.
//
module lru_block_tag_store_unit #(
    parameter int unsigned CAPACITY      = 16,
    parameter int unsigned BLOCK_ID_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lbts_pkg::PORT_ID_W-1:0] s_block_id,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_hit,
    output logic [lbts_pkg::SLOT_W-1:0]    m_slot,
    output logic                           m_evicted,
    output logic [lbts_pkg::PORT_ID_W-1:0] m_victim_block_id
);

    localparam int unsigned AW  = $clog2(CAPACITY);
    localparam int unsigned IDW = BLOCK_ID_BITS + lbts_pkg::PORT_ID_W;
    localparam int unsigned SXW = AW + lbts_pkg::SLOT_W;

    lbts_pkg::store_ctl_t     ctl;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic [BLOCK_ID_BITS-1:0] wr_tag;
    logic [AW-1:0]            wr_rank;
    logic [BLOCK_ID_BITS-1:0] rd_tag;
    logic [AW-1:0]            rd_rank;
    logic [CAPACITY-1:0]      valid_vec;

    logic                     res_valid;
    logic                     res_ready;
    logic                     res_hit;
    logic [AW-1:0]            res_slot;
    logic                     res_evict;
    logic [BLOCK_ID_BITS-1:0] res_victim;

    logic [IDW-1:0]           in_id_wide;
    logic [IDW-1:0]           victim_wide;
    logic [SXW-1:0]           slot_wide;

    logic                           m_valid_reg, m_valid_next;
    logic                           m_hit_reg;
    logic [lbts_pkg::SLOT_W-1:0]    m_slot_reg;
    logic                           m_evicted_reg;
    logic [lbts_pkg::PORT_ID_W-1:0] m_victim_reg;

    // Keep only the compared id bits
    assign in_id_wide = IDW'(s_block_id);

    lbts_ctrl #(
        .CAPACITY      (CAPACITY),
        .BLOCK_ID_BITS (BLOCK_ID_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_id      (in_id_wide[BLOCK_ID_BITS-1:0]),
        .ctl        (ctl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .wr_tag     (wr_tag),
        .wr_rank    (wr_rank),
        .rd_tag     (rd_tag),
        .rd_rank    (rd_rank),
        .valid_vec  (valid_vec),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_hit    (res_hit),
        .res_slot   (res_slot),
        .res_evict  (res_evict),
        .res_victim (res_victim)
    );

    lbts_store #(
        .CAPACITY      (CAPACITY),
        .BLOCK_ID_BITS (BLOCK_ID_BITS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .wr_tag    (wr_tag),
        .wr_rank   (wr_rank),
        .rd_tag    (rd_tag),
        .rd_rank   (rd_rank),
        .valid_vec (valid_vec)
    );

    // Output register: load when empty or being drained
    assign res_ready   = !m_valid_reg || m_ready;
    assign victim_wide = IDW'(res_victim);
    assign slot_wide   = SXW'(res_slot);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_hit_reg     <= res_hit;
            m_slot_reg    <= slot_wide[lbts_pkg::SLOT_W-1:0];
            m_evicted_reg <= res_evict;
            m_victim_reg  <= victim_wide[lbts_pkg::PORT_ID_W-1:0];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_hit             = m_hit_reg;
    assign m_slot            = m_slot_reg;
    assign m_evicted         = m_evicted_reg;
    assign m_victim_block_id = m_victim_reg;

endmodule
